// ===== sv/ufe_pkg.sv =====
// union-find engine package: field widths, handshake bundles and sequencer codes
// shared by ufe_seq and union_find_engine_top; no dependencies
package ufe_pkg;

  localparam int UFE_NODES    = 1024;
  localparam int UFE_NODE_W   = 10;
  localparam int UFE_THR_W    = 11;
  localparam int UFE_SIZE_W   = 11;
  localparam int UFE_RANK_W   = 4;
  localparam int UFE_IN_DW    = 32;
  localparam int UFE_OUT_DW   = 24;

  localparam logic MODE_UNITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                  mode;
    logic [UFE_NODE_W-1:0] node_a;
    logic [UFE_NODE_W-1:0] node_b;
    logic [UFE_THR_W-1:0]  threshold;
  } req_t;

  typedef struct packed {
    logic                  merged;
    logic                  found;
    logic [UFE_NODE_W-1:0] vertex;
    logic [UFE_SIZE_W-1:0] component_size;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_COMP_RD,
    ST_COMP_WR,
    ST_LINK_LO,
    ST_LINK_HI,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_A_FIRST,
    PH_B,
    PH_A_FINAL
  } phase_e;

endpackage

// ===== sv/ufe_table.sv =====
// disjoint-set table memory: one write port, one read port with registered data
// each word holds parent link, rank and set size; no package dependency
module ufe_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 25
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ufe_seq.sv =====
// union-find sequencer: clearing pass, root walks with path compression, linking
// depends on ufe_pkg and drives the ufe_table memory
module ufe_seq #(
  parameter int NODES = ufe_pkg::UFE_NODES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          ready_o,
  input  logic          start_i,
  input  ufe_pkg::req_t req_i,
  output logic          res_valid_o,
  input  logic          res_take_i,
  output ufe_pkg::res_t res_o
);

  import ufe_pkg::*;

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int DW = AW + UFE_RANK_W + UFE_SIZE_W;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  req_t   req_q, req_d;

  logic [AW-1:0]         cur_q, cur_d;
  logic [AW-1:0]         start_q, start_d;
  logic [AW-1:0]         root_q, root_d;
  logic [UFE_RANK_W-1:0] root_rank_q, root_rank_d;
  logic [UFE_SIZE_W-1:0] root_size_q, root_size_d;
  logic [AW-1:0]         ra_q, ra_d;
  logic [UFE_RANK_W-1:0] rank_a_q, rank_a_d;
  logic [UFE_SIZE_W-1:0] size_a_q, size_a_d;
  logic [UFE_SIZE_W-1:0] csize_q, csize_d;
  logic                  merged_q, merged_d;
  logic [AW-1:0]         clr_q, clr_d;

  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [DW-1:0] rdata;

  logic [AW-1:0]         rd_parent;
  logic [UFE_RANK_W-1:0] rd_rank;
  logic [UFE_SIZE_W-1:0] rd_size;

  logic                  a_in, b_in;
  logic [AW-1:0]         a_addr, b_addr;
  logic                  a_lower, rank_eq;
  logic [UFE_SIZE_W-1:0] size_sum;
  logic [UFE_RANK_W-1:0] rank_inc;
  logic                  q_found;

  ufe_table #(
    .DEPTH (NODES),
    .AW    (AW),
    .DW    (DW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (cur_q),
    .rdata_o (rdata)
  );

  assign rd_parent = rdata[DW-1 -: AW];
  assign rd_rank   = rdata[UFE_SIZE_W +: UFE_RANK_W];
  assign rd_size   = rdata[UFE_SIZE_W-1:0];

  // node ranges are checked against the table depth, not the field width
  assign a_in   = (32'(req_i.node_a) < 32'(NODES));
  assign b_in   = (32'(req_q.node_b) < 32'(NODES));
  assign a_addr = AW'(req_i.node_a);
  assign b_addr = AW'(req_q.node_b);

  // shared link arithmetic: rank compare and size add
  assign a_lower  = (rank_a_q < root_rank_q);
  assign rank_eq  = (rank_a_q == root_rank_q);
  assign size_sum = size_a_q + root_size_q;
  assign rank_inc = rank_a_q + {{(UFE_RANK_W-1){1'b0}}, rank_eq};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      phase_q  <= PH_A_FIRST;
      clr_q    <= '0;
      merged_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      clr_q    <= clr_d;
      merged_q <= merged_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    cur_q       <= cur_d;
    start_q     <= start_d;
    root_q      <= root_d;
    root_rank_q <= root_rank_d;
    root_size_q <= root_size_d;
    ra_q        <= ra_d;
    rank_a_q    <= rank_a_d;
    size_a_q    <= size_a_d;
    csize_q     <= csize_d;
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    req_d       = req_q;
    cur_d       = cur_q;
    start_d     = start_q;
    root_d      = root_q;
    root_rank_d = root_rank_q;
    root_size_d = root_size_q;
    ra_d        = ra_q;
    rank_a_d    = rank_a_q;
    size_a_d    = size_a_q;
    csize_d     = csize_q;
    merged_d    = merged_q;
    clr_d       = clr_q;
    we          = 1'b0;
    waddr       = cur_q;
    wdata       = rdata;
    ready_o     = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = {clr_q, {UFE_RANK_W{1'b0}}, UFE_SIZE_W'(1)};
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(NODES - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        ready_o = 1'b1;
        if (start_i) begin
          req_d    = req_i;
          merged_d = 1'b0;
          cur_d    = a_addr;
          start_d  = a_addr;
          phase_d  = PH_A_FIRST;
          if (a_in) begin
            state_d = ST_FIND_RD;
          end else begin
            csize_d = UFE_SIZE_W'(1);
            state_d = ST_DONE;
          end
        end
      end

      ST_FIND_RD: begin
        state_d = ST_FIND_CHK;
      end

      ST_FIND_CHK: begin
        if (rd_parent == cur_q) begin
          root_d      = cur_q;
          root_rank_d = rd_rank;
          root_size_d = rd_size;
          cur_d       = start_q;
          state_d     = ST_COMP_RD;
        end else begin
          cur_d   = rd_parent;
          state_d = ST_FIND_RD;
        end
      end

      ST_COMP_RD: begin
        if (cur_q != root_q) begin
          state_d = ST_COMP_WR;
        end else begin
          unique case (phase_q)
            PH_A_FIRST: begin
              if (req_q.mode == MODE_UNITE && b_in) begin
                ra_d     = root_q;
                rank_a_d = root_rank_q;
                size_a_d = root_size_q;
                cur_d    = b_addr;
                start_d  = b_addr;
                phase_d  = PH_B;
                state_d  = ST_FIND_RD;
              end else begin
                csize_d = root_size_q;
                state_d = ST_DONE;
              end
            end
            PH_B: begin
              if (root_q != ra_q) begin
                state_d = ST_LINK_LO;
              end else begin
                csize_d = size_a_q;
                state_d = ST_DONE;
              end
            end
            PH_A_FINAL: begin
              csize_d = root_size_q;
              state_d = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_COMP_WR: begin
        we      = 1'b1;
        waddr   = cur_q;
        wdata   = {root_q, rd_rank, rd_size};
        cur_d   = rd_parent;
        state_d = ST_COMP_RD;
      end

      // hang the lower-ranked root under the other one; on a tie node_b's root goes under
      ST_LINK_LO: begin
        we       = 1'b1;
        merged_d = 1'b1;
        if (a_lower) begin
          waddr = ra_q;
          wdata = {root_q, rank_a_q, size_a_q};
        end else begin
          waddr = root_q;
          wdata = {ra_q, root_rank_q, root_size_q};
        end
        state_d = ST_LINK_HI;
      end

      // surviving root takes the summed size, and a rank step on a tie
      ST_LINK_HI: begin
        we = 1'b1;
        if (a_lower) begin
          waddr = root_q;
          wdata = {root_q, root_rank_q, size_sum};
        end else begin
          waddr = ra_q;
          wdata = {ra_q, rank_inc, size_sum};
        end
        cur_d   = AW'(req_q.node_a);
        start_d = AW'(req_q.node_a);
        phase_d = PH_A_FINAL;
        state_d = ST_FIND_RD;
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign q_found = (req_q.mode == MODE_QUERY) && (req_q.threshold <= csize_q);

  always_comb begin
    res_o.merged         = (req_q.mode == MODE_UNITE) && merged_q;
    res_o.found          = q_found;
    res_o.vertex         = q_found ? req_q.node_a : '0;
    res_o.component_size = csize_q;
  end

endmodule

// ===== sv/union_find_engine_top.sv =====
// union-find engine top level: stream handshakes, output register, sequencer
// depends on ufe_pkg, ufe_seq and ufe_table
//
// Disjoint-set engine over NODES nodes with union by rank and path compression.
// After reset the block runs a clearing pass over the table that makes every
// node its own root (rank 0, size 1); s_axis_tready_o stays low until it ends.
// A unite transaction (tuser 0) finds the roots of node_a and node_b, pointing
// every node on both paths straight at its root, links the lower-ranked root
// under the other (on a tie node_b's root goes under node_a's root, whose rank
// grows), adds the sizes and walks node_a once more for the final size. A query
// transaction (tuser 1) finds node_a's root and reports found, with vertex set
// to node_a, when the set holds at least threshold nodes. Node indices at or
// above NODES stand for lone nodes of size 1 and leave the table untouched.
// Exactly one result transaction follows each input transaction. All work goes
// through a single table memory with one read and one write port: a root walk
// reads one link at a time, compression rewrites each node on the path, and
// linking writes the lower root and then the surviving root. With union by rank
// paths stay within log2(NODES) links, and compression keeps most paths short.
// Input is taken only while the sequencer is idle; a finished result waits in
// the output register so the next transaction can start while it is still unread.
module union_find_engine_top #(
  parameter int NODES = ufe_pkg::UFE_NODES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave side
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // node_a [9:0], node_b [19:10], threshold [30:20], zero [31]
  input  logic [ufe_pkg::UFE_IN_DW-1:0]  s_axis_tdata_i,
  // mode (0 unite, 1 query)
  input  logic                          s_axis_tuser_i,
  // master side
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // merged [0], found [1], vertex [11:2], component_size [22:12], zero [23]
  output logic [ufe_pkg::UFE_OUT_DW-1:0] m_axis_tdata_o
);

  import ufe_pkg::*;

  logic seq_ready;
  logic seq_start;
  req_t req;
  logic res_valid;
  logic res_take;
  res_t res;

  logic                  m_valid_q, m_valid_d;
  logic [UFE_OUT_DW-1:0] m_data_q, m_data_d;

  // unpack the input transaction
  always_comb begin
    req.mode      = s_axis_tuser_i;
    req.node_a    = s_axis_tdata_i[UFE_NODE_W-1:0];
    req.node_b    = s_axis_tdata_i[2*UFE_NODE_W-1:UFE_NODE_W];
    req.threshold = s_axis_tdata_i[2*UFE_NODE_W +: UFE_THR_W];
  end

  assign s_axis_tready_o = seq_ready;
  assign seq_start       = s_axis_tvalid_i && seq_ready;

  ufe_seq #(
    .NODES (NODES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ready_o     (seq_ready),
    .start_i     (seq_start),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  // output register: loads when empty or being drained this cycle
  assign res_take = res_valid && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    if (res_take) begin
      m_valid_d = 1'b1;
      m_data_d  = UFE_OUT_DW'({res.component_size, res.vertex, res.found, res.merged});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule
